// File: sv/afr_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the alarm frame receiver.
// Used by every module of the block; depends on nothing.
package afr_pkg;

    // Parser phase: which byte of the frame comes next
    typedef enum logic [2:0] {
        PH_DEST,
        PH_COUNT,
        PH_STATION,
        PH_STATE,
        PH_UNIT,
        PH_CODE,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_CRC  = 2'd1;
    localparam logic [1:0] STATUS_ADDR = 2'd2;

    // Depth of the queue between the parser and the result stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified word passed from the parser to the result stage
    typedef struct packed {
        logic       kind;
        logic [7:0] station;
        logic [7:0] state;
        logic [7:0] index;
        logic [7:0] unit;
        logic [7:0] code;
        logic [7:0] count;
        logic       crc_bad;
        logic       addr_bad;
    } rec_t;

    // One byte of CRC-16/MODBUS, reflected, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: sv/afr_front.sv
// Front end of the alarm frame receiver: byte parser, CRC accumulator and word classifier.
// Depends on afr_pkg; feeds afr_queue.
module afr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      own_address,
    output logic            rec_push,
    output afr_pkg::rec_t   rec
);

    afr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next, crc_upd;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  station_reg, station_next;
    logic [7:0]  state_reg, state_next;
    logic [7:0]  unit_reg, unit_next;
    logic [7:0]  index_reg, index_next;

    assign crc_upd = afr_pkg::crc_byte(crc_reg, rx_byte);

    // Advance the phase on each accepted byte
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                afr_pkg::PH_DEST:    phase_next = afr_pkg::PH_COUNT;
                afr_pkg::PH_COUNT:   phase_next = afr_pkg::PH_STATION;
                afr_pkg::PH_STATION: phase_next = afr_pkg::PH_STATE;
                afr_pkg::PH_STATE:
                    phase_next = (left_reg == 8'd0) ? afr_pkg::PH_CRC_LO : afr_pkg::PH_UNIT;
                afr_pkg::PH_UNIT:    phase_next = afr_pkg::PH_CODE;
                afr_pkg::PH_CODE:
                    phase_next = (left_reg == 8'd1) ? afr_pkg::PH_CRC_LO : afr_pkg::PH_UNIT;
                afr_pkg::PH_CRC_LO:  phase_next = afr_pkg::PH_CRC_HI;
                afr_pkg::PH_CRC_HI:  phase_next = afr_pkg::PH_DEST;
                default:             phase_next = afr_pkg::PH_DEST;
            endcase
        end
    end

    // Capture header and entry bytes, run the CRC
    always_comb
    begin
        crc_next     = crc_reg;
        dest_next    = dest_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        station_next = station_reg;
        state_next   = state_reg;
        unit_next    = unit_reg;
        index_next   = index_reg;
        if (accept)
        begin
            crc_next = crc_upd;
            case (phase_reg)
                afr_pkg::PH_DEST:    dest_next = rx_byte;
                afr_pkg::PH_COUNT:
                begin
                    count_next = rx_byte;
                    left_next  = rx_byte;
                    index_next = 8'd0;
                end
                afr_pkg::PH_STATION: station_next = rx_byte;
                afr_pkg::PH_STATE:   state_next = rx_byte;
                afr_pkg::PH_UNIT:    unit_next = rx_byte;
                afr_pkg::PH_CODE:
                begin
                    index_next = index_reg + 8'd1;
                    left_next  = left_reg - 8'd1;
                end
                afr_pkg::PH_CRC_HI:  crc_next = afr_pkg::CRC_INIT;
                default:             crc_next = crc_upd;
            endcase
        end
    end

    // Classify: emit a word on each alarm code byte and on the last CRC byte
    always_comb
    begin
        rec          = '0;
        rec.station  = station_reg;
        rec.state    = state_reg;
        rec.count    = count_reg;
        rec.index    = index_reg;
        rec.unit     = unit_reg;
        rec.code     = rx_byte;
        rec.crc_bad  = (crc_upd != 16'd0);
        rec.addr_bad = (dest_reg != own_address);
        rec_push     = 1'b0;
        case (phase_reg)
            afr_pkg::PH_CODE:
            begin
                rec.kind = afr_pkg::KIND_ENTRY;
                rec_push = accept;
            end
            afr_pkg::PH_CRC_HI:
            begin
                rec.kind = afr_pkg::KIND_END;
                rec_push = accept;
            end
            default:
            begin
                rec.kind = afr_pkg::KIND_ENTRY;
                rec_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= afr_pkg::PH_DEST;
            crc_reg     <= afr_pkg::CRC_INIT;
            dest_reg    <= 8'd0;
            count_reg   <= 8'd0;
            left_reg    <= 8'd0;
            station_reg <= 8'd0;
            state_reg   <= 8'd0;
            unit_reg    <= 8'd0;
            index_reg   <= 8'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            dest_reg    <= dest_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            station_reg <= station_next;
            state_reg   <= state_next;
            unit_reg    <= unit_next;
            index_reg   <= index_next;
        end
    end

    // A frame-end word restarts the parser and the CRC
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push && rec.kind == afr_pkg::KIND_END |=>
            phase_reg == afr_pkg::PH_DEST && crc_reg == afr_pkg::CRC_INIT)
        else $error("frame end did not restart the parser");

    // An entry word leaves the entry counter one lower
    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push && rec.kind == afr_pkg::KIND_ENTRY |=> left_reg == $past(left_reg) - 8'd1)
        else $error("entry counter did not step");

endmodule

// File: sv/afr_queue.sv
// Short queue of classified words between the parser and the result stage.
// Depends on afr_pkg.
module afr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  afr_pkg::rec_t   push_rec,
    output logic            full,
    input  logic            pop,
    output afr_pkg::rec_t   pop_rec,
    output logic            not_empty
);

    afr_pkg::rec_t                 mem [afr_pkg::QUEUE_DEPTH];
    logic [afr_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [afr_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [afr_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          do_push, do_pop;

    localparam logic [afr_pkg::QPTR_W-1:0] PTR_LAST = afr_pkg::QPTR_W'(afr_pkg::QUEUE_DEPTH - 1);
    localparam logic [afr_pkg::QCNT_W-1:0] CNT_FULL = afr_pkg::QCNT_W'(afr_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = mem[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("word pushed into a full queue");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue level out of range");

endmodule

// File: sv/afr_back.sv
// Result stage of the alarm frame receiver: resolves frame status and holds the output word.
// Depends on afr_pkg; drained from afr_queue.
module afr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  afr_pkg::rec_t   q_rec,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic            item_kind,
    output logic [7:0]      station_address,
    output logic [7:0]      station_state,
    output logic [7:0]      entry_index,
    output logic [7:0]      unit_offset,
    output logic [7:0]      alarm_code,
    output logic [7:0]      entry_count,
    output logic [1:0]      frame_status
);

    logic       valid_reg, valid_next;
    logic       kind_reg, kind_next;
    logic [7:0] station_reg, station_next;
    logic [7:0] state_reg, state_next;
    logic [7:0] index_reg, index_next;
    logic [7:0] unit_reg, unit_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] count_reg, count_next;
    logic [1:0] status_reg, status_next;
    logic [1:0] status_end;

    // Load when the output slot is free or being drained this cycle
    assign q_pop = q_not_empty && (!valid_reg || pop);

    // CRC failure wins over address mismatch
    always_comb
    begin
        if (q_rec.crc_bad)
            status_end = afr_pkg::STATUS_CRC;
        else if (q_rec.addr_bad)
            status_end = afr_pkg::STATUS_ADDR;
        else
            status_end = afr_pkg::STATUS_OK;
    end

    // Format the next output word
    always_comb
    begin
        valid_next   = valid_reg;
        kind_next    = kind_reg;
        station_next = station_reg;
        state_next   = state_reg;
        index_next   = index_reg;
        unit_next    = unit_reg;
        code_next    = code_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        if (q_pop)
        begin
            valid_next   = 1'b1;
            kind_next    = q_rec.kind;
            station_next = q_rec.station;
            state_next   = q_rec.state;
            count_next   = q_rec.count;
            if (q_rec.kind == afr_pkg::KIND_END)
            begin
                index_next  = 8'd0;
                unit_next   = 8'd0;
                code_next   = 8'd0;
                status_next = status_end;
            end
            else
            begin
                index_next  = q_rec.index;
                unit_next   = q_rec.unit;
                code_next   = q_rec.code;
                status_next = afr_pkg::STATUS_OK;
            end
        end
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            kind_reg    <= afr_pkg::KIND_ENTRY;
            station_reg <= 8'd0;
            state_reg   <= 8'd0;
            index_reg   <= 8'd0;
            unit_reg    <= 8'd0;
            code_reg    <= 8'd0;
            count_reg   <= 8'd0;
            status_reg  <= afr_pkg::STATUS_OK;
        end
        else
        begin
            valid_reg   <= valid_next;
            kind_reg    <= kind_next;
            station_reg <= station_next;
            state_reg   <= state_next;
            index_reg   <= index_next;
            unit_reg    <= unit_next;
            code_reg    <= code_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
        end
    end

    assign empty           = !valid_reg;
    assign item_kind       = kind_reg;
    assign station_address = station_reg;
    assign station_state   = state_reg;
    assign entry_index     = index_reg;
    assign unit_offset     = unit_reg;
    assign alarm_code      = code_reg;
    assign entry_count     = count_reg;
    assign frame_status    = status_reg;

    // Entry words never carry a status
    a_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == afr_pkg::KIND_ENTRY |-> status_reg == afr_pkg::STATUS_OK)
        else $error("entry word with nonzero status");

    // A held word is not replaced until it is taken
    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !pop |=> valid_reg && $stable(kind_reg) && $stable(code_reg)
            && $stable(index_reg) && $stable(status_reg))
        else $error("output word changed while stalled");

endmodule

// File: sv/alarm_frame_receiver.sv
// Top level of the alarm frame receiver: address register, parser, queue and result stage.
// Depends on afr_pkg, afr_front, afr_queue and afr_back.
//
// Usage:
//   Bytes of a serial alarm frame enter on rx_byte; a byte is taken at a clock edge with
//   push high and full low. The frame is destination, entry count, station address,
//   station state, count pairs of (unit address, alarm code), then two CRC-16/MODBUS bytes.
//   Results leave as a queue: while empty is low the oldest word sits on the result ports
//   and is taken at an edge with pop high. One entry word follows each alarm code byte;
//   one frame-end word with frame_status follows the last CRC byte (CRC error reported
//   ahead of an address mismatch).
//   own_address is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
//   Throughput: one byte per cycle while full is low, with a combinational byte CRC update.
//   Path: a result is written into the queue at the edge that takes its last byte, then
//   loaded into the output register once that is empty or being drained by pop.
//   Stall: while pop is low the output word holds and the four-word queue fills; full
//   rises once it is full, and the parser waits.
//   Reset: clears the parser to expect a destination byte, the CRC to 0xFFFF, the queue
//   and output register to empty, and own_address to 0.
module alarm_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        item_kind,
    output logic [7:0]  station_address,
    output logic [7:0]  station_state,
    output logic [7:0]  entry_index,
    output logic [7:0]  unit_offset,
    output logic [7:0]  alarm_code,
    output logic [7:0]  entry_count,
    output logic [1:0]  frame_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]    own_addr_reg, own_addr_next;
    logic          accept;
    logic          rec_push, q_pop, q_not_empty;
    afr_pkg::rec_t rec, q_rec;

    assign cfg_ready = 1'b1;

    // Hold the receiver address
    always_comb
    begin
        own_addr_next = own_addr_reg;
        if (cfg_valid && cfg_ready)
            own_addr_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_addr_reg <= 8'd0;
        else
            own_addr_reg <= own_addr_next;
    end

    assign accept = push && !full;

    afr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .own_address (own_addr_reg),
        .rec_push    (rec_push),
        .rec         (rec)
    );

    afr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_rec  (rec),
        .full      (full),
        .pop       (q_pop),
        .pop_rec   (q_rec),
        .not_empty (q_not_empty)
    );

    afr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_rec           (q_rec),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .item_kind       (item_kind),
        .station_address (station_address),
        .station_state   (station_state),
        .entry_index     (entry_index),
        .unit_offset     (unit_offset),
        .alarm_code      (alarm_code),
        .entry_count     (entry_count),
        .frame_status    (frame_status)
    );

endmodule
